@@ rtl/core/bf_pkg.sv @@
package bf_pkg;

	// Operation codes carried in s_tuser.
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Results are reported for at most sixteen vertices, so vertex fields are four bits.
	localparam int VERT_CAP = 16;
	localparam int VERT_W   = 4;
	localparam int VCNT_W   = 5;
	localparam int DIST_W   = 32;
	localparam int COST_W   = 16;

	localparam logic [VCNT_W-1:0] VCOUNT_RESET = 5'd16;
	localparam logic [DIST_W-1:0] DIST_UNREACHED = 32'h7FFF_FFFF;
	localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 40;

	typedef struct packed {
		logic load_edge;
		logic clear_edges;
		logic run_init;
		logic edge_rd;
		logic edge_next;
		logic vert_next;
		logic pass_next;
		logic dist_rd;
		logic relax_wr;
		logic neg_set;
		logic emit_start;
		logic emit_rd;
		logic emit_ld;
	} cmd_t;

	typedef struct packed {
		logic edge_done;
		logic vert_last;
		logic check_pass;
		logic edge_ok;
		logic better;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/core/bf_ctrl.sv @@
module bf_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bf_pkg::IN_TUSER_W-1:0] op,
	input  bf_pkg::stat_t                 st,
	output bf_pkg::cmd_t                  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_RELAX = 3'd3;
	localparam logic [2:0] ST_EMRD  = 3'd4;
	localparam logic [2:0] ST_EMLD  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (op)
						bf_pkg::OP_ADD:   cmd.load_edge = 1'b1;
						bf_pkg::OP_CLEAR: cmd.clear_edges = 1'b1;
						bf_pkg::OP_RUN: begin
							cmd.run_init = 1'b1;
							state_d      = ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (st.edge_done) begin
					if (!st.vert_last) begin
						cmd.vert_next = 1'b1;
					end else if (st.check_pass) begin
						cmd.emit_start = 1'b1;
						state_d        = ST_EMRD;
					end else begin
						cmd.pass_next = 1'b1;
					end
				end else begin
					cmd.edge_rd = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (st.edge_ok) begin
					cmd.dist_rd = 1'b1;
					state_d     = ST_RELAX;
				end else begin
					cmd.edge_next = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			ST_RELAX: begin
				cmd.edge_next = 1'b1;
				if (st.better) begin
					// The final pass only looks; it never updates a distance.
					if (st.check_pass) cmd.neg_set = 1'b1;
					else               cmd.relax_wr = 1'b1;
				end
				state_d = ST_SCAN;
			end
			ST_EMRD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_EMLD;
			end
			ST_EMLD: begin
				if (st.out_free) begin
					cmd.emit_ld = 1'b1;
					state_d     = st.vert_last ? ST_IDLE : ST_EMRD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/bf_dpath.sv @@
module bf_dpath #(
	parameter int MAX_VERTICES = 16,
	parameter int MAX_EDGES    = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bf_pkg::cmd_t                   cmd,
	output bf_pkg::stat_t                  st,
	input  logic [bf_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                           cfg_valid,
	input  logic [bf_pkg::VCNT_W-1:0]      cfg_data,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bf_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                           m_tlast
);

	localparam int ET_W = $clog2(MAX_EDGES + 1);
	localparam int EI_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int VLIM = (MAX_VERTICES < bf_pkg::VERT_CAP) ? MAX_VERTICES : bf_pkg::VERT_CAP;
	localparam logic [ET_W-1:0] EDGE_FULL = ET_W'(MAX_EDGES);
	localparam int VW = bf_pkg::VERT_W;
	localparam int DW = bf_pkg::DIST_W;
	localparam int CW = bf_pkg::COST_W;

	// Request fields.
	logic [VW-1:0] in_from;
	logic [VW-1:0] in_to;
	logic [CW-1:0] in_cost;
	logic [VW-1:0] in_src;

	assign in_from = s_tdata[3:0];
	assign in_to   = s_tdata[7:4];
	assign in_cost = s_tdata[23:8];
	assign in_src  = s_tdata[27:24];

	// Edge store.
	logic [VW-1:0] tail_mem [MAX_EDGES];
	logic [VW-1:0] head_mem [MAX_EDGES];
	logic [CW-1:0] cost_mem [MAX_EDGES];
	logic [VW-1:0] rd_tail_q;
	logic [VW-1:0] rd_head_q;
	logic [CW-1:0] rd_cost_q;

	logic [ET_W-1:0] edge_total_q;
	logic            overflow_q;
	logic            store_full;
	logic            edge_wr;

	// Distance store and reached flags.
	logic [DW-1:0]               dist_mem [bf_pkg::VERT_CAP];
	logic [DW-1:0]               dist_a_q;
	logic [DW-1:0]               dist_b_q;
	logic [bf_pkg::VERT_CAP-1:0] reached_q;
	logic [bf_pkg::VERT_CAP-1:0] src_mask;
	logic                        dist_wr;
	logic [VW-1:0]               dist_wr_addr;
	logic [DW-1:0]               dist_wr_data;

	logic [bf_pkg::VCNT_W-1:0] vcount_q;
	logic [bf_pkg::VCNT_W-1:0] n_act;
	logic [bf_pkg::VCNT_W-1:0] n_last;
	logic [VW-1:0]             vert_q;
	logic [VW-1:0]             pass_q;
	logic [ET_W-1:0]           ecnt_q;
	logic                      neg_q;
	logic                      src_ok;

	logic [DW:0]   sum_wide;
	logic [DW-1:0] cand;

	logic                          out_valid_q;
	logic [bf_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic                          out_last_q;

	always_comb begin
		if (vcount_q == '0)                         n_act = 5'd1;
		else if (vcount_q > bf_pkg::VCNT_W'(VLIM))  n_act = bf_pkg::VCNT_W'(VLIM);
		else                                        n_act = vcount_q;
	end

	assign n_last     = n_act - 5'd1;
	assign src_ok     = ({1'b0, in_src} < n_act);
	assign src_mask   = src_ok ? ({{(bf_pkg::VERT_CAP-1){1'b0}}, 1'b1} << in_src) : '0;
	assign store_full = (edge_total_q == EDGE_FULL);
	assign edge_wr    = cmd.load_edge && !store_full;

	// Saturating sum of the tail distance and the edge weight.
	assign sum_wide = {dist_a_q[DW-1], dist_a_q} + {{(DW+1-CW){rd_cost_q[CW-1]}}, rd_cost_q};
	always_comb begin
		if (sum_wide[DW] != sum_wide[DW-1]) cand = sum_wide[DW] ? bf_pkg::DIST_MIN
		                                                         : bf_pkg::DIST_UNREACHED;
		else                                cand = sum_wide[DW-1:0];
	end

	assign st.edge_done  = (ecnt_q == edge_total_q);
	assign st.vert_last  = ({1'b0, vert_q} == n_last);
	assign st.check_pass = ({1'b0, pass_q} == n_last);
	assign st.edge_ok    = (rd_tail_q == vert_q) && ({1'b0, rd_head_q} < n_act)
	                       && reached_q[vert_q];
	assign st.better     = !reached_q[rd_head_q] || ($signed(cand) < $signed(dist_b_q));
	assign st.out_free   = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (edge_wr) begin
			tail_mem[edge_total_q[EI_W-1:0]] <= in_from;
			head_mem[edge_total_q[EI_W-1:0]] <= in_to;
			cost_mem[edge_total_q[EI_W-1:0]] <= in_cost;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.edge_rd) begin
			rd_tail_q <= tail_mem[ecnt_q[EI_W-1:0]];
			rd_head_q <= head_mem[ecnt_q[EI_W-1:0]];
			rd_cost_q <= cost_mem[ecnt_q[EI_W-1:0]];
		end
	end

	assign dist_wr      = (cmd.run_init && src_ok) || cmd.relax_wr;
	assign dist_wr_addr = cmd.run_init ? in_src : rd_head_q;
	assign dist_wr_data = cmd.run_init ? '0 : cand;

	always_ff @(posedge clk) begin
		if (dist_wr) dist_mem[dist_wr_addr] <= dist_wr_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.dist_rd || cmd.emit_rd) dist_a_q <= dist_mem[vert_q];
		if (cmd.dist_rd)                dist_b_q <= dist_mem[rd_head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q     <= bf_pkg::VCOUNT_RESET;
			edge_total_q <= '0;
			overflow_q   <= 1'b0;
			reached_q    <= '0;
			neg_q        <= 1'b0;
			vert_q       <= '0;
			pass_q       <= '0;
			ecnt_q       <= '0;
		end else begin
			if (cfg_valid) vcount_q <= cfg_data;
			if (edge_wr) edge_total_q <= edge_total_q + ET_W'(1);
			if (cmd.load_edge && store_full) overflow_q <= 1'b1;
			if (cmd.clear_edges) begin
				edge_total_q <= '0;
				overflow_q   <= 1'b0;
			end
			if (cmd.run_init) begin
				reached_q <= src_mask;
				neg_q  <= 1'b0;
				vert_q <= '0;
				pass_q <= '0;
				ecnt_q <= '0;
			end
			if (cmd.relax_wr) reached_q[rd_head_q] <= 1'b1;
			if (cmd.neg_set) neg_q <= 1'b1;
			if (cmd.edge_next) ecnt_q <= ecnt_q + ET_W'(1);
			if (cmd.vert_next) begin
				vert_q <= vert_q + VW'(1);
				ecnt_q <= '0;
			end
			if (cmd.pass_next) begin
				pass_q <= pass_q + VW'(1);
				vert_q <= '0;
				ecnt_q <= '0;
			end
			if (cmd.emit_start) vert_q <= '0;
			if (cmd.emit_ld) vert_q <= vert_q + VW'(1);
		end
	end

	// Output register: it holds one result, so new requests can enter while the last one waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_ld) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			out_data_q <= {1'b0, overflow_q, neg_q, reached_q[vert_q],
			               reached_q[vert_q] ? dist_a_q : bf_pkg::DIST_UNREACHED, vert_q};
			out_last_q <= st.vert_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

@@ rtl/core/bellman_ford_shortest_paths_core.sv @@
// Single-source shortest paths by Bellman-Ford. Requests on the s_ side add an edge, start a
// run from a source vertex or clear the edge store; adds and clears are taken one per cycle.
// A run clears the reached flags, sets the source distance to zero, and makes n-1 relaxation
// passes and one checking pass, where n is the active vertex count, each pass visiting tails
// in ascending order and, for each tail, every stored edge in insertion order through the
// single read port of the edge memory. The n results then follow in vertex order, each one
// waiting while the output register still holds the one before, the last one flagged by
// m_tlast. Requests are refused while a run is in progress; the last result may still wait
// in the output register when the next request is taken. Unreached vertices report a
// distance of 2147483647, and sums saturate to the signed 32-bit range. The user must
// write vertex_count only while no run is open; the block itself does not enforce this.
module bellman_ford_shortest_paths_core #(
	parameter int MAX_VERTICES = 16,
	parameter int MAX_EDGES    = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// from_vertex[3:0], to_vertex[7:4], edge_weight[23:8], source_vertex[27:24], zero fill
	input  logic [bf_pkg::IN_TDATA_W-1:0]  s_tdata,
	// operation[1:0]
	input  logic [bf_pkg::IN_TUSER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// vertex[3:0], distance[35:4], reachable[36], negative_cycle[37], edges_dropped[38], zero fill
	output logic [bf_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bf_pkg::VCNT_W-1:0]      cfg_data
);

	bf_pkg::cmd_t  cmd;
	bf_pkg::stat_t st;

	assign cfg_ready = 1'b1;

	bf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.st       (st),
		.cmd      (cmd)
	);

	bf_dpath #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

@@ rtl/core/bf_checker.sv @@
module bf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [bf_pkg::IN_TUSER_W-1:0]  s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [bf_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                           m_tlast
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// An unreached vertex always reports the largest distance.
	a_unreached_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[36] |-> m_tdata[35:4] == bf_pkg::DIST_UNREACHED)
		else $error("unreached vertex with a finite distance");

	// A run request keeps the block busy for at least the following cycle.
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == bf_pkg::OP_RUN |=> !s_tready)
		else $error("request taken straight after a run request");

	// Edge adds, clears and unknown codes leave the block free for the next request.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != bf_pkg::OP_RUN |=> s_tready)
		else $error("block stalled after an edge load or clear");

endmodule

bind bellman_ford_shortest_paths_core bf_checker u_bf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

@@ tb/sv/tb.sv @@
module tb;

	localparam int IN_TDATA_W  = bf_pkg::IN_TDATA_W;
	localparam int IN_TUSER_W  = bf_pkg::IN_TUSER_W;
	localparam int OUT_TDATA_W = bf_pkg::OUT_TDATA_W;
	localparam int VCNT_W      = bf_pkg::VCNT_W;
	localparam int VERT_CAP    = bf_pkg::VERT_CAP;
	localparam logic [4:0]  VCOUNT_RESET   = bf_pkg::VCOUNT_RESET;
	localparam logic [31:0] DIST_UNREACHED = bf_pkg::DIST_UNREACHED;
	localparam logic [1:0]  OP_ADD   = bf_pkg::OP_ADD;
	localparam logic [1:0]  OP_RUN   = bf_pkg::OP_RUN;
	localparam logic [1:0]  OP_CLEAR = bf_pkg::OP_CLEAR;

	localparam int MAX_E = 64;
	localparam int RANDOM_REQUESTS = 440;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam longint DIST_TOP = 64'sd2147483647;
	localparam longint DIST_BOTTOM = -64'sd2147483648;

	typedef enum logic [1:0] {STEP_REQUEST, STEP_VCOUNT, STEP_CHECKED} step_kind_t;
	typedef enum logic [1:0] {MIX_NORMAL, MIX_OVERFLOW, MIX_FULL} phase_mix_t;

	typedef struct packed {
		step_kind_t  kind;
		logic [1:0]  op;
		logic [3:0]  tail;
		logic [3:0]  head;
		logic [15:0] weight;
		logic [3:0]  src;
		logic [4:0]  vcount;
		logic [31:0] distance;
		logic        reached;
		logic        neg_cycle;
		logic        dropped;
	} directed_step_t;

	typedef struct packed {
		logic [3:0]  vertex;
		logic [31:0] distance;
		logic        reached;
		logic        neg_cycle;
		logic        dropped;
		logic        last;
	} vertex_report_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// from_vertex[3:0], to_vertex[7:4], edge_weight[23:8], source_vertex[27:24], zero fill
	logic [IN_TDATA_W-1:0]  s_tdata;
	// operation[1:0]
	logic [IN_TUSER_W-1:0]  s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	// vertex[3:0], distance[35:4], reachable[36], negative_cycle[37], edges_dropped[38], zero fill
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [VCNT_W-1:0]      cfg_data;

	// Shadow copy of the edge store and of the vertex count register.
	logic [3:0]         stored_tail [MAX_E];
	logic [3:0]         stored_head [MAX_E];
	logic signed [15:0] stored_cost [MAX_E];
	int unsigned        stored_edges = 0;
	bit                 store_overflowed = 1'b0;
	logic [4:0]         vertex_limit = VCOUNT_RESET;

	vertex_report_t pending_reports [$];
	int unsigned    mismatch_count = 0;
	int unsigned    requests_sent = 0;
	bit             tx_calm = 1'b0;
	bit             rx_calm = 1'b0;

	// Rows that are fully checked use a vertex count of zero or one, so they yield a single result.
	directed_step_t plan [28] = '{
		'{STEP_VCOUNT,  OP_ADD,    4'd0,  4'd0,  16'h0000, 4'd0,  5'd1,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_CHECKED, OP_RUN,    4'd0,  4'd0,  16'h0000, 4'd0,  5'd0,  32'd0, 1'b1, 1'b0, 1'b0},
		'{STEP_CHECKED, OP_RUN,    4'd0,  4'd0,  16'h0000, 4'd15, 5'd0,
			DIST_UNREACHED, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_ADD,    4'd0,  4'd0,  16'hFFFB, 4'd0,  5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_CHECKED, OP_RUN,    4'd0,  4'd0,  16'h0000, 4'd0,  5'd0,  32'd0, 1'b1, 1'b1, 1'b0},
		'{STEP_VCOUNT,  OP_ADD,    4'd0,  4'd0,  16'h0000, 4'd0,  5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_CHECKED, OP_RUN,    4'd0,  4'd0,  16'h0000, 4'd0,  5'd0,  32'd0, 1'b1, 1'b1, 1'b0},
		'{STEP_REQUEST, OP_UNUSED, 4'd15, 4'd15, 16'hFFFF, 4'd15, 5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_CLEAR,  4'd0,  4'd0,  16'h0000, 4'd0,  5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_CHECKED, OP_RUN,    4'd0,  4'd0,  16'h0000, 4'd0,  5'd0,  32'd0, 1'b1, 1'b0, 1'b0},
		'{STEP_VCOUNT,  OP_ADD,    4'd0,  4'd0,  16'h0000, 4'd0,  5'd31, 32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_ADD,    4'd0,  4'd1,  16'h7FFF, 4'd0,  5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_ADD,    4'd1,  4'd2,  16'h8000, 4'd0,  5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_ADD,    4'd2,  4'd15, 16'h0001, 4'd0,  5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_ADD,    4'd5,  4'd6,  16'h0007, 4'd0,  5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_ADD,    4'd15, 4'd3,  16'h0000, 4'd0,  5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_ADD,    4'd0,  4'd2,  16'h8000, 4'd0,  5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_ADD,    4'd2,  4'd1,  16'h7FFF, 4'd0,  5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_ADD,    4'd3,  4'd0,  16'hFFFF, 4'd0,  5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_RUN,    4'd0,  4'd0,  16'h0000, 4'd0,  5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_RUN,    4'd0,  4'd0,  16'h0000, 4'd5,  5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_VCOUNT,  OP_ADD,    4'd0,  4'd0,  16'h0000, 4'd0,  5'd4,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_RUN,    4'd0,  4'd0,  16'h0000, 4'd0,  5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_RUN,    4'd0,  4'd0,  16'h0000, 4'd3,  5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_RUN,    4'd0,  4'd0,  16'h0000, 4'd15, 5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_VCOUNT,  OP_ADD,    4'd0,  4'd0,  16'h0000, 4'd0,  5'd16, 32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_CLEAR,  4'd0,  4'd0,  16'h0000, 4'd0,  5'd0,  32'd0, 1'b0, 1'b0, 1'b0},
		'{STEP_REQUEST, OP_RUN,    4'd0,  4'd0,  16'h0000, 4'd15, 5'd0,  32'd0, 1'b0, 1'b0, 1'b0}
	};

	bellman_ford_shortest_paths_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned active_count();
		if (vertex_limit == 0) return 1;
		if (vertex_limit > VERT_CAP) return VERT_CAP;
		return vertex_limit;
	endfunction

	// Mostly vertices in use, now and then any index so that stray endpoints appear.
	function automatic logic [3:0] pick_vertex(input int unsigned n);
		if ($urandom_range(0, 4) == 0) return 4'($urandom_range(0, 15));
		return 4'($urandom_range(0, n - 1));
	endfunction

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 3))
			0: return 16'($urandom());
			1: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
			default: return 16'($urandom_range(0, 70)) - 16'd20;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] wanted);
		$display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, wanted);
		mismatch_count++;
	endtask

	// Appends one expected result to the queue of outstanding results.
	task automatic queue_report(input vertex_report_t rep);
		pending_reports = {pending_reports, rep};
	endtask

	task automatic write_vcount(input logic [4:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		vertex_limit = value;
	endtask

	// Holds the request side idle until every result is in and the block has gone quiet.
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_request(input logic [1:0] op, input logic [3:0] tail,
		input logic [3:0] head, input logic [15:0] weight, input logic [3:0] src,
		input bit predict);
		int unsigned        gap;
		int unsigned        n;
		int unsigned        hd;
		logic signed [31:0] vdist [VERT_CAP];
		bit                 reached [VERT_CAP];
		bit                 neg;
		longint             sum;
		logic signed [31:0] cand;
		vertex_report_t     rep;

		gap = tx_calm ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'd0, src, weight, head, tail};
		do @(posedge clk); while (!s_tready);
		if (op != OP_UNUSED) requests_sent++;

		if (op == OP_ADD) begin
			if (stored_edges < MAX_E) begin
				stored_tail[stored_edges] = tail;
				stored_head[stored_edges] = head;
				stored_cost[stored_edges] = weight;
				stored_edges++;
			end else begin
				store_overflowed = 1'b1;
			end
		end else if (op == OP_CLEAR) begin
			stored_edges = 0;
			store_overflowed = 1'b0;
		end else if (op == OP_RUN && predict) begin
			n = active_count();
			for (int v = 0; v < VERT_CAP; v++) begin
				reached[v] = 1'b0;
				vdist[v] = DIST_UNREACHED;
			end
			if (src < n) begin
				reached[src] = 1'b1;
				vdist[src] = 0;
			end
			neg = 1'b0;
			// n-1 relaxing sweeps; the final sweep only looks for an edge that still improves.
			for (int p = 0; p < n; p++) begin
				for (int v = 0; v < n; v++) begin
					for (int e = 0; e < stored_edges; e++) begin
						hd = stored_head[e];
						if (stored_tail[e] == v && hd < n && reached[v]) begin
							sum = longint'(vdist[v]) + longint'(stored_cost[e]);
							if (sum > DIST_TOP) sum = DIST_TOP;
							if (sum < DIST_BOTTOM) sum = DIST_BOTTOM;
							cand = 32'(sum);
							if (!reached[hd] || cand < vdist[hd]) begin
								if (p == n - 1) begin
									neg = 1'b1;
								end else begin
									vdist[hd] = cand;
									reached[hd] = 1'b1;
								end
							end
						end
					end
				end
			end
			for (int v = 0; v < n; v++) begin
				rep = '{4'(v), vdist[v], reached[v], neg, store_overflowed, v == n - 1};
				queue_report(rep);
			end
		end
	endtask

	task automatic send_random(input logic [1:0] op, input int unsigned n);
		send_request(op, pick_vertex(n), pick_vertex(n), pick_weight(), pick_vertex(n), 1'b1);
	endtask

	initial begin : result_check
		vertex_report_t want;
		int unsigned    stall;

		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending_reports.size() == 0) begin
				report_mismatch("result with nothing outstanding", 64'(m_tdata), 64'd0);
			end else begin
				want = pending_reports.pop_front();
				if (m_tdata[3:0] != want.vertex)
					report_mismatch("vertex", 64'(m_tdata[3:0]), 64'(want.vertex));
				if (m_tdata[35:4] != want.distance)
					report_mismatch("distance", 64'(m_tdata[35:4]), 64'(want.distance));
				if (m_tdata[36] != want.reached)
					report_mismatch("reachable", 64'(m_tdata[36]), 64'(want.reached));
				if (m_tdata[37] != want.neg_cycle)
					report_mismatch("negative_cycle", 64'(m_tdata[37]), 64'(want.neg_cycle));
				if (m_tdata[38] != want.dropped)
					report_mismatch("edges_dropped", 64'(m_tdata[38]), 64'(want.dropped));
				if (m_tlast != want.last)
					report_mismatch("tlast", 64'(m_tlast), 64'(want.last));
			end
		end
	end

	initial begin : stimulus
		directed_step_t step;
		phase_mix_t     mix;
		logic [4:0]     vc;
		int unsigned    phase_no;
		int unsigned    n;
		int unsigned    count;
		int unsigned    base;
		int unsigned    r;
		bit             heavy;
		vertex_report_t rep;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			step = plan[i];
			case (step.kind)
				STEP_VCOUNT: begin
					settle_block();
					write_vcount(step.vcount);
				end
				STEP_CHECKED: begin
					send_request(step.op, step.tail, step.head, step.weight, step.src, 1'b0);
					rep = '{4'd0, step.distance, step.reached, step.neg_cycle, step.dropped,
						1'b1};
					queue_report(rep);
				end
				default: begin
					send_request(step.op, step.tail, step.head, step.weight, step.src, 1'b1);
				end
			endcase
		end

		// Each phase sets a vertex count, builds or extends a graph and runs it.
		base = requests_sent;
		phase_no = 0;
		while (requests_sent < base + RANDOM_REQUESTS) begin
			settle_block();
			phase_no++;
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			if (phase_no == 3 || $urandom_range(0, 24) == 0)
				mix = MIX_OVERFLOW;
			else if (phase_no == 6)
				mix = MIX_FULL;
			else
				mix = MIX_NORMAL;

			case (mix)
				MIX_OVERFLOW: vc = 5'($urandom_range(2, 4));
				MIX_FULL: vc = 5'd16;
				default: begin
					r = $urandom_range(0, 99);
					if (r < 5)
						vc = 5'd0;
					else if (r < 10)
						vc = 5'($urandom_range(17, 31));
					else if (r < 20)
						vc = 5'($urandom_range(11, 16));
					else if (r < 35)
						vc = 5'($urandom_range(6, 10));
					else
						vc = 5'($urandom_range(1, 5));
				end
			endcase
			write_vcount(vc);
			n = active_count();
			// Runs grow longer with more vertices and more edges, so large graphs stay sparse.
			heavy = (n > 10);
			if (mix != MIX_NORMAL || heavy || stored_edges > 32 || $urandom_range(0, 1) == 1)
				send_random(OP_CLEAR, n);

			case (mix)
				MIX_OVERFLOW: begin
					while (stored_edges < MAX_E) send_random(OP_ADD, n);
					count = $urandom_range(1, 4);
					repeat (count) send_random(OP_ADD, n);
					send_random(OP_RUN, n);
					if ($urandom_range(0, 1) == 1) begin
						send_random(OP_CLEAR, n);
						send_random(OP_RUN, n);
					end
				end
				MIX_FULL: begin
					repeat (MAX_E) send_random(OP_ADD, n);
					repeat (2) send_random(OP_RUN, n);
				end
				default: begin
					count = heavy ? $urandom_range(0, 12) : $urandom_range(0, 16);
					repeat (count) begin
						send_random(OP_ADD, n);
						r = $urandom_range(0, 15);
						if (r == 0)
							send_random(OP_CLEAR, n);
						else if (r == 1)
							send_random(OP_UNUSED, n);
						else if (r < 5 && !heavy)
							send_random(OP_RUN, n);
					end
					send_random(OP_RUN, n);
				end
			endcase
		end

		settle_block();
		repeat (30) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : watchdog
		#200000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/bf_pkg.sv
rtl/core/bf_ctrl.sv
rtl/core/bf_dpath.sv
rtl/core/bellman_ford_shortest_paths_core.sv
rtl/core/bf_checker.sv
tb/sv/tb.sv
